// ===== rtl/spa_pkg.sv =====
`timescale 1ns / 1ps

package spa_pkg;

  // fixed field widths
  localparam int POS_FW = 6;
  localparam int SUM_W  = 32;

  // default number of dense positions
  localparam int LENGTH_DEF = 64;

  // item action codes
  localparam logic ACT_SCATTER = 1'b0;
  localparam logic ACT_GATHER  = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [POS_FW-1:0]       position;
    logic signed [SUM_W-1:0] addend;
  } spa_in_t;

  typedef struct packed {
    logic [POS_FW-1:0]       out_position;
    logic signed [SUM_W-1:0] out_sum;
    logic                    valid_res;
    logic                    last;
  } spa_out_t;

  // control from the sequencer to the index list
  typedef struct packed {
    logic              append;
    logic [POS_FW-1:0] app_pos;
    logic              clear;
    logic              rd_en;
    logic [POS_FW-1:0] rd_addr;
  } spa_list_ctl_t;

endpackage

// ===== rtl/spa_sum_ram.sv =====
`timescale 1ns / 1ps

module spa_sum_ram import spa_pkg::*; #(
  parameter int LENGTH = LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(LENGTH)-1:0]   rd_addr,
  output logic signed [SUM_W-1:0]     rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(LENGTH)-1:0]   wr_addr,
  input  logic signed [SUM_W-1:0]     wr_data
);

  logic signed [SUM_W-1:0] mem [LENGTH];

  // read returns the old value on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/spa_idx_list.sv =====
`timescale 1ns / 1ps

module spa_idx_list import spa_pkg::*; #(
  parameter int LENGTH = LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spa_list_ctl_t                 ctl,
  output logic [POS_FW-1:0]             rd_data,
  output logic [$clog2(LENGTH+1)-1:0]   count
);

  localparam int POS_W = $clog2(LENGTH);
  localparam int CNT_W = $clog2(LENGTH + 1);

  logic [POS_FW-1:0] mem [LENGTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              app_we;

  assign app_we = ctl.append && (count_r < CNT_W'(LENGTH));

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (app_we) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (app_we) begin
      mem[count_r[POS_W-1:0]] <= ctl.app_pos;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr[POS_W-1:0]];
    end
  end

  assign count = count_r;

endmodule

// ===== rtl/sparse_accumulator_core.sv =====
`timescale 1ns / 1ps

// sparse accumulator: scatter adds into per-position sums, gather drains them
//
// input channel: an item is taken on a rising edge with start high and busy
// low. a scatter item (action 0) adds addend into the sum of position and
// appends the position to the index list on its first use; positions at or
// above LENGTH are dropped. scatters stream at one item per clock while busy
// is low; a read-modify-write of the sum memory follows in the next cycle
// and a same-position scatter on the next cycle is forwarded.
// a gather item (action 1) raises busy and walks the index list in insertion
// order through a three-stage pipe (index memory read, sum memory read,
// output register), one entry per clock. busy stays high until the last
// entry reaches the output register; an empty list gives one result with
// valid_res low and last set.
// result channel: out_strobe marks each result for exactly one cycle and the
// receiver cannot stall it; last marks the final result of a gather.
// reset: synchronous, active low; clears the occupied bits and the list
// count. sum and index memories need no clearing pass.

module sparse_accumulator_core import spa_pkg::*; #(
  parameter int LENGTH = LENGTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spa_in_t  in_item,
  output logic     out_strobe,
  output spa_out_t out_item
);

  localparam int POS_W = $clog2(LENGTH);
  localparam int CNT_W = $clog2(LENGTH + 1);

  // sequencer states
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_GATHER = 1'b1;

  logic state_r, state_nxt;

  // input decode
  logic accept, acc_sc, acc_ga;

  // occupied mark per position, cleared at reset
  logic [LENGTH-1:0] occ_r, occ_nxt;

  // scatter write stage
  logic                    wr_v_r;
  logic [POS_W-1:0]        wr_pos_r;
  logic signed [SUM_W-1:0] wr_add_r;
  logic                    fwd_v_r, fwd_v_nxt;
  logic signed [SUM_W-1:0] fwd_sum_r;
  logic                    wr_hit, wr_room, wr_we, wr_new;
  logic signed [SUM_W-1:0] wr_base, wr_sum;

  // gather pipe
  logic [CNT_W-1:0]  gk_r, gk_nxt;
  logic              s1_v_r, s1_last_r;
  logic              s2_v_r, s2_last_r;
  logic [POS_FW-1:0] s2_pos_r;
  logic              g_run, g_empty, g_iss, g_done;

  // memory connections
  spa_list_ctl_t           list_ctl;
  logic [POS_FW-1:0]       idx_rd;
  logic [CNT_W-1:0]        list_cnt;
  logic                    sum_rd_en;
  logic [POS_W-1:0]        sum_rd_addr;
  logic signed [SUM_W-1:0] sum_rd;

  // output register
  logic     out_strobe_r, out_strobe_nxt;
  spa_out_t out_item_r, out_item_nxt;

  assign busy   = (state_r == ST_GATHER);
  assign accept = start && !busy;
  assign acc_sc = accept && (in_item.action == ACT_SCATTER)
                  && (int'(in_item.position) < LENGTH);
  assign acc_ga = accept && (in_item.action == ACT_GATHER);

  // read-modify-write of the sum, forwarded sum covers back-to-back hits
  always_comb begin
    wr_hit  = occ_r[wr_pos_r];
    wr_room = (list_cnt < CNT_W'(LENGTH));
    wr_we   = wr_v_r && (wr_hit || wr_room);
    wr_new  = wr_v_r && !wr_hit && wr_room;
    wr_base = fwd_v_r ? fwd_sum_r : sum_rd;
    wr_sum  = wr_hit ? (wr_base + wr_add_r) : wr_add_r;
    fwd_v_nxt = acc_sc && wr_we && (in_item.position[POS_W-1:0] == wr_pos_r);
  end

  // gather control
  assign g_run   = (state_r == ST_GATHER);
  assign g_empty = g_run && (list_cnt == '0);
  assign g_iss   = g_run && (gk_r < list_cnt);
  assign g_done  = s2_v_r && s2_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_ga) begin
          state_nxt = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (g_empty || g_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    gk_nxt = gk_r;
    if (acc_ga) begin
      gk_nxt = '0;
    end else if (g_iss) begin
      gk_nxt = gk_r + CNT_W'(1);
    end
  end

  // occupied bits: set by a first scatter, dropped as gather emits the entry
  always_comb begin
    occ_nxt = occ_r;
    if (wr_new) begin
      occ_nxt[wr_pos_r] = 1'b1;
    end
    if (s2_v_r) begin
      occ_nxt[s2_pos_r[POS_W-1:0]] = 1'b0;
    end
  end

  always_comb begin
    list_ctl.append  = wr_new;
    list_ctl.app_pos = POS_FW'(wr_pos_r);
    list_ctl.clear   = g_done;
    list_ctl.rd_en   = g_iss;
    list_ctl.rd_addr = POS_FW'(gk_r);
  end

  // sum memory read port shared by scatter lookup and gather drain
  assign sum_rd_en   = acc_sc || s1_v_r;
  assign sum_rd_addr = s1_v_r ? idx_rd[POS_W-1:0] : in_item.position[POS_W-1:0];

  always_comb begin
    out_strobe_nxt = s2_v_r || g_empty;
    if (s2_v_r) begin
      out_item_nxt.out_position = s2_pos_r;
      out_item_nxt.out_sum      = sum_rd;
      out_item_nxt.valid_res    = 1'b1;
      out_item_nxt.last         = s2_last_r;
    end else begin
      out_item_nxt.out_position = '0;
      out_item_nxt.out_sum      = '0;
      out_item_nxt.valid_res    = 1'b0;
      out_item_nxt.last         = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gk_r         <= '0;
      occ_r        <= '0;
      wr_v_r       <= 1'b0;
      fwd_v_r      <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      gk_r         <= gk_nxt;
      occ_r        <= occ_nxt;
      wr_v_r       <= acc_sc;
      fwd_v_r      <= fwd_v_nxt;
      s1_v_r       <= g_iss;
      s2_v_r       <= s1_v_r;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wr_pos_r   <= in_item.position[POS_W-1:0];
    wr_add_r   <= in_item.addend;
    fwd_sum_r  <= wr_sum;
    s1_last_r  <= (gk_r == (list_cnt - CNT_W'(1)));
    s2_last_r  <= s1_last_r;
    s2_pos_r   <= idx_rd;
    out_item_r <= out_item_nxt;
  end

  spa_idx_list #(
    .LENGTH (LENGTH)
  ) u_idx_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (list_ctl),
    .rd_data (idx_rd),
    .count   (list_cnt)
  );

  spa_sum_ram #(
    .LENGTH (LENGTH)
  ) u_sum_ram (
    .clk     (clk),
    .rd_en   (sum_rd_en),
    .rd_addr (sum_rd_addr),
    .rd_data (sum_rd),
    .wr_en   (wr_we),
    .wr_addr (wr_pos_r),
    .wr_data (wr_sum)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // a gather never starts while a scatter write is still pending
  a_no_wr_in_gather: assert property (@(posedge clk) disable iff (!rst_n)
    g_run |-> !wr_v_r)
    else $error("scatter write overlaps gather");

  // the list never holds more entries than positions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    list_cnt <= CNT_W'(LENGTH))
    else $error("list count beyond length");

  // an entry being drained is still marked occupied
  a_drain_occ: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> occ_r[s2_pos_r[POS_W-1:0]])
    else $error("drained entry not occupied");

  // an empty result always closes its gather
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_item_r.valid_res) |-> out_item_r.last)
    else $error("empty result without last");

endmodule
